[rtl/gtpu_pkg.sv]
// Shared constants for the GTP-U encapsulator.
`default_nettype none
package gtpu_pkg;

  localparam int MAX_FRAME_BYTES = 1514;
  localparam int HDR_BYTES       = 58;
  localparam int MAX_INNER_LEN   = MAX_FRAME_BYTES - HDR_BYTES;

  localparam int LEN_W    = 11;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int HDR_CNT_W = $clog2(HDR_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_MAC  = 3'd0,
    REG_DST_MAC  = 3'd1,
    REG_SRC_IPV4 = 3'd2,
    REG_DST_IPV4 = 3'd3,
    REG_UDP_SRC  = 3'd4,
    REG_IP_TTL   = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] UDP_SRC_RESET = 16'd12345;
  localparam logic [7:0]  TTL_RESET     = 8'd64;
  localparam logic [15:0] GTPU_UDP_PORT = 16'd2152;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IPV4_VER_IHL  = 8'h45;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
  localparam logic [7:0]  GTPU_FLAGS    = 8'h34;
  localparam logic [7:0]  GTPU_TYPE     = 8'hFF;
  localparam logic [7:0]  EXT_PDU_SESS  = 8'h85;
  localparam logic [7:0]  EXT_LEN_ONE   = 8'h01;
  localparam logic [7:0]  PDU_TYPE_UL   = 8'h10;
  localparam logic [7:0]  QFI_MASK      = 8'h3F;

  localparam logic [15:0] IP_LEN_ADD   = 16'd44;
  localparam logic [15:0] UDP_LEN_ADD  = 16'd24;
  localparam logic [15:0] GTPU_LEN_ADD = 16'd8;

endpackage
`default_nettype wire

[rtl/gtpu_encapsulator_top.sv]
// GTP-U encapsulator top level: header generation and byte pass-through.
//
// Inner packet bytes enter one per item and leave as an Ethernet/IPv4/UDP/GTP-U
// frame, one byte per output item. Bytes after the first of a packet pass
// through at one per cycle while the output is not stalled. The first byte of
// each packet is preceded by the 58-byte outer header, all sent through the
// single output byte register. The input is held stalled during the header
// burst. The IPv4 checksum comes from a short free-running pipeline that
// settles well before its bytes are sent. The user must write configuration
// registers only while the block is idle; the block does not enforce this.
`default_nettype none
module gtpu_encapsulator_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gtpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gtpu_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           byte_last,
  input  wire logic [gtpu_pkg::LEN_W-1:0]     inner_length,
  input  wire logic [31:0]                    tunnel_id,
  input  wire logic [7:0]                     flow_qfi,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_last
);
  import gtpu_pkg::*;

  logic [47:0] src_mac_addr;
  logic [47:0] dst_mac_addr;
  logic [31:0] outer_src_ipv4;
  logic [31:0] outer_dst_ipv4;
  logic [15:0] udp_src_port;
  logic [7:0]  ip_ttl;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_mac_addr   <= '0;
      dst_mac_addr   <= '0;
      outer_src_ipv4 <= '0;
      outer_dst_ipv4 <= '0;
      udp_src_port   <= UDP_SRC_RESET;
      ip_ttl         <= TTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_MAC:  src_mac_addr   <= cfg_data;
        REG_DST_MAC:  dst_mac_addr   <= cfg_data;
        REG_SRC_IPV4: outer_src_ipv4 <= cfg_data[31:0];
        REG_DST_IPV4: outer_dst_ipv4 <= cfg_data[31:0];
        REG_UDP_SRC:  udp_src_port   <= cfg_data[15:0];
        REG_IP_TTL:   ip_ttl         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // held item
  logic                 held_valid;
  logic                 held_first;
  logic [7:0]           held_byte;
  logic                 held_last;
  logic [LEN_W-1:0]     held_len;
  logic [31:0]          held_teid;
  logic [5:0]           held_qfi;
  logic                 mid_packet;
  logic [HDR_CNT_W-1:0] hdr_cnt;

  logic slot_free;
  logic send_hdr;
  logic release_item;
  logic in_accept;
  logic [LEN_W-1:0] len_sat;

  assign slot_free    = !out_valid || !out_stall;
  assign send_hdr     = held_valid && held_first &&
                        (hdr_cnt != HDR_CNT_W'(HDR_BYTES));
  assign release_item = held_valid && slot_free && !send_hdr;
  assign in_stall     = held_valid && !release_item;
  assign in_accept    = in_valid && !in_stall;
  assign len_sat      = (inner_length > LEN_W'(MAX_INNER_LEN)) ?
                        LEN_W'(MAX_INNER_LEN) : inner_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      mid_packet <= 1'b0;
      hdr_cnt    <= '0;
    end else begin
      if (in_accept) begin
        held_valid <= 1'b1;
        mid_packet <= !byte_last;
      end else if (release_item) begin
        held_valid <= 1'b0;
      end
      if (release_item) begin
        hdr_cnt <= '0;
      end else if (send_hdr && slot_free) begin
        hdr_cnt <= hdr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      held_first <= !mid_packet;
      held_byte  <= data_byte;
      held_last  <= byte_last;
      if (!mid_packet) begin
        held_len  <= len_sat;
        held_teid <= tunnel_id;
        held_qfi  <= flow_qfi[5:0] & QFI_MASK[5:0];
      end
    end
  end

  // length fields
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [15:0] gtp_msg_len;

  assign ip_len      = 16'(held_len) + IP_LEN_ADD;
  assign udp_len     = 16'(held_len) + UDP_LEN_ADD;
  assign gtp_msg_len = 16'(held_len) + GTPU_LEN_ADD;

  // IPv4 header checksum pipeline
  logic [17:0] ck_s1;
  logic [19:0] ck_s2;
  logic [15:0] ck_sum;
  logic [16:0] ck_fold1;
  logic [16:0] ck_fold2;

  assign ck_fold1 = 17'(ck_s2[19:16]) + 17'(ck_s2[15:0]);
  assign ck_fold2 = 17'(ck_fold1[15:0]) + 17'(ck_fold1[16]);

  always_ff @(posedge clk) begin
    ck_s1  <= 18'(outer_src_ipv4[31:16]) + 18'(outer_src_ipv4[15:0]) +
              18'(outer_dst_ipv4[31:16]) + 18'(outer_dst_ipv4[15:0]);
    ck_s2  <= 20'(ck_s1) + 20'({IPV4_VER_IHL, 8'h00}) + 20'(ip_len) +
              20'({ip_ttl, IP_PROTO_UDP});
    ck_sum <= ~ck_fold2[15:0];
  end

  // header byte select
  logic [7:0] hdr_byte;

  always_comb begin
    case (hdr_cnt)
      6'd0:  hdr_byte = dst_mac_addr[47:40];
      6'd1:  hdr_byte = dst_mac_addr[39:32];
      6'd2:  hdr_byte = dst_mac_addr[31:24];
      6'd3:  hdr_byte = dst_mac_addr[23:16];
      6'd4:  hdr_byte = dst_mac_addr[15:8];
      6'd5:  hdr_byte = dst_mac_addr[7:0];
      6'd6:  hdr_byte = src_mac_addr[47:40];
      6'd7:  hdr_byte = src_mac_addr[39:32];
      6'd8:  hdr_byte = src_mac_addr[31:24];
      6'd9:  hdr_byte = src_mac_addr[23:16];
      6'd10: hdr_byte = src_mac_addr[15:8];
      6'd11: hdr_byte = src_mac_addr[7:0];
      6'd12: hdr_byte = ETH_TYPE_IPV4[15:8];
      6'd13: hdr_byte = ETH_TYPE_IPV4[7:0];
      6'd14: hdr_byte = IPV4_VER_IHL;
      6'd16: hdr_byte = ip_len[15:8];
      6'd17: hdr_byte = ip_len[7:0];
      6'd22: hdr_byte = ip_ttl;
      6'd23: hdr_byte = IP_PROTO_UDP;
      6'd24: hdr_byte = ck_sum[15:8];
      6'd25: hdr_byte = ck_sum[7:0];
      6'd26: hdr_byte = outer_src_ipv4[31:24];
      6'd27: hdr_byte = outer_src_ipv4[23:16];
      6'd28: hdr_byte = outer_src_ipv4[15:8];
      6'd29: hdr_byte = outer_src_ipv4[7:0];
      6'd30: hdr_byte = outer_dst_ipv4[31:24];
      6'd31: hdr_byte = outer_dst_ipv4[23:16];
      6'd32: hdr_byte = outer_dst_ipv4[15:8];
      6'd33: hdr_byte = outer_dst_ipv4[7:0];
      6'd34: hdr_byte = udp_src_port[15:8];
      6'd35: hdr_byte = udp_src_port[7:0];
      6'd36: hdr_byte = GTPU_UDP_PORT[15:8];
      6'd37: hdr_byte = GTPU_UDP_PORT[7:0];
      6'd38: hdr_byte = udp_len[15:8];
      6'd39: hdr_byte = udp_len[7:0];
      6'd42: hdr_byte = GTPU_FLAGS;
      6'd43: hdr_byte = GTPU_TYPE;
      6'd44: hdr_byte = gtp_msg_len[15:8];
      6'd45: hdr_byte = gtp_msg_len[7:0];
      6'd46: hdr_byte = held_teid[31:24];
      6'd47: hdr_byte = held_teid[23:16];
      6'd48: hdr_byte = held_teid[15:8];
      6'd49: hdr_byte = held_teid[7:0];
      6'd53: hdr_byte = EXT_PDU_SESS;
      6'd54: hdr_byte = EXT_LEN_ONE;
      6'd55: hdr_byte = PDU_TYPE_UL;
      6'd56: hdr_byte = {2'b00, held_qfi};
      default: hdr_byte = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && held_valid) begin
      if (send_hdr) begin
        out_byte <= hdr_byte;
        out_last <= 1'b0;
      end else begin
        out_byte <= held_byte;
        out_last <= held_last;
      end
    end
  end

endmodule
`default_nettype wire
